@@ hw/rtl/rgb_to_hsv_converter_defines.svh @@
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent-check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhc check failed");
// implication a fixed number of cycles later
`define RHC_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("rhc latency check failed");
`else
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RHC_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif

`endif

@@ hw/rtl/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Word types, pipeline stage types, constants and the divider step function.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int COMP_W    = 8;
   localparam int HUE_W     = 15;
   localparam int SAT_W     = 17;
   localparam int SPAN_W    = 8;
   localparam int DIFF_W    = 9;
   localparam int T_W       = 11;
   localparam int NUM_W     = 24;
   localparam int NQ_W      = 17;              // numerator bits left / quotient bits
   localparam int DIV_W     = 9;               // divisor is twice span or twice max
   localparam int REM_W     = 10;
   localparam int DIV_STEPS = NQ_W;
   localparam int LATENCY   = DIV_STEPS + 2;
   localparam int HUE_LIMIT = 23040;

   // hue sector, picked by which component is the minimum
   localparam logic [2:0] SECTOR_BLUE_MIN  = 3'd1;
   localparam logic [2:0] SECTOR_RED_MIN   = 3'd3;
   localparam logic [2:0] SECTOR_GREEN_MIN = 3'd5;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [COMP_W-1:0] brightness;
      logic              is_gray;
   } hsv_type;

   typedef struct packed {
      logic                     valid;
      logic [2:0]               sector;
      logic signed [DIFF_W-1:0] diff;
      logic [SPAN_W-1:0]        span;
      logic [COMP_W-1:0]        brightness;
      logic                     is_gray;
   } prep_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NQ_W-1:0]  nq;
      logic [DIV_W-1:0] div;
   } lane_type;

   typedef struct packed {
      lane_type          hue_lane;
      lane_type          sat_lane;
      logic [COMP_W-1:0] brightness;
      logic              is_gray;
   } stage_data_type;

   typedef struct packed {
      logic           valid;
      stage_data_type data;
   } stage_type;

   // one restoring-division step: pull in the next numerator bit, emit one quotient bit
   function automatic lane_type div_step(input lane_type lane);
      lane_type         res;
      logic [REM_W-1:0] shifted;
      logic             ge;
      shifted = {lane.rem[REM_W-2:0], lane.nq[NQ_W-1]};
      ge      = (shifted >= {1'b0, lane.div});
      res.rem = ge ? (shifted - {1'b0, lane.div}) : shifted;
      res.nq  = {lane.nq[NQ_W-2:0], ge};
      res.div = lane.div;
      return res;
   endfunction

endpackage

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined pixel color conversion: hue, saturation and value from 8-bit RGB.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns its result as a one-cycle
// word on rsp_result marked by rsp_strobe; the receiver must take it in that
// cycle. The pipeline is two front stages (max/min and sector, then the
// rounded numerators) followed by one register stage per quotient bit of the
// 17-bit divider that both hue and saturation share. req_busy is high only
// while reset is applied. Hue is in 1/64 degree and saturation in 1/65536,
// both rounded to nearest, ties upward; gray pixels return hue and saturation
// of zero with is_gray set.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  rhc_pkg::pixel_type req_pixel,
   output logic               rsp_strobe,
   output rhc_pkg::hsv_type   rsp_result
);

   logic               accept;
   rhc_pkg::prep_type  prep;
   rhc_pkg::stage_type stages [rhc_pkg::DIV_STEPS+1];
   rhc_pkg::stage_type last;

   assign req_busy = reset;
   assign accept   = req_start & ~req_busy;

   rhc_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pixel (req_pixel),
      .prep     (prep)
   );

   rhc_numer u_numer (
      .clock    (clock),
      .reset    (reset),
      .prep     (prep),
      .dn_stage (stages[0])
   );

   for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++) begin : g_div
      rhc_div_stage u_div_stage (
         .clock    (clock),
         .reset    (reset),
         .up_stage (stages[i]),
         .dn_stage (stages[i+1])
      );
   end

   assign last = stages[rhc_pkg::DIV_STEPS];

   // drop divider output for gray pixels: span was zero there
   always_comb begin
      rsp_strobe            = last.valid;
      rsp_result.brightness = last.data.brightness;
      rsp_result.is_gray    = last.data.is_gray;
      if (last.data.is_gray) begin
         rsp_result.hue        = '0;
         rsp_result.saturation = '0;
      end else begin
         rsp_result.hue        = last.data.hue_lane.nq[rhc_pkg::HUE_W-1:0];
         rsp_result.saturation = last.data.sat_lane.nq;
      end
   end

   `RHC_ASSERT_DELAY(a_latency, clock, reset, accept, rhc_pkg::LATENCY, rsp_strobe)
   `RHC_ASSERT_DELAY(a_no_spurious, clock, reset, !accept, rhc_pkg::LATENCY, !rsp_strobe)
   `RHC_ASSERT_IMPLY(a_color_range, clock, reset, rsp_strobe && !rsp_result.is_gray, rsp_result.saturation != 0 && rsp_result.brightness != 0 && rsp_result.hue < rhc_pkg::HUE_LIMIT)

endmodule

@@ hw/rtl/rhc_prep.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter, stage 1
// Finds max and min, the hue sector, the signed difference and the span.
// ----------------------------------------------------------------------------
module rhc_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rhc_pkg::pixel_type in_pixel,
   output rhc_pkg::prep_type  prep
);

   logic [rhc_pkg::COMP_W-1:0] mx;
   logic [rhc_pkg::COMP_W-1:0] mn;
   logic                       valid_ff;
   logic                       valid_in;
   rhc_pkg::prep_type          data_ff;
   rhc_pkg::prep_type          data_in;

   always_comb begin
      mx = in_pixel.red;
      mn = in_pixel.red;
      if (in_pixel.green > mx) mx = in_pixel.green;
      if (in_pixel.blue > mx) mx = in_pixel.blue;
      if (in_pixel.green < mn) mn = in_pixel.green;
      if (in_pixel.blue < mn) mn = in_pixel.blue;
   end

   always_comb begin
      valid_in           = in_valid;
      data_in.valid      = in_valid;
      data_in.span       = mx - mn;
      data_in.brightness = mx;
      data_in.is_gray    = (mx == mn);
      // ties go red first, then blue, then green
      if (in_pixel.red == mn) begin
         data_in.sector = rhc_pkg::SECTOR_RED_MIN;
         data_in.diff   = $signed({1'b0, in_pixel.green}) - $signed({1'b0, in_pixel.blue});
      end else if (in_pixel.blue == mn) begin
         data_in.sector = rhc_pkg::SECTOR_BLUE_MIN;
         data_in.diff   = $signed({1'b0, in_pixel.red}) - $signed({1'b0, in_pixel.green});
      end else begin
         data_in.sector = rhc_pkg::SECTOR_GREEN_MIN;
         data_in.diff   = $signed({1'b0, in_pixel.blue}) - $signed({1'b0, in_pixel.red});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      prep       = data_ff;
      prep.valid = valid_ff;
   end

endmodule

@@ hw/rtl/rhc_numer.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter, stage 2
// Builds the rounded hue and saturation numerators and loads both divider lanes.
// ----------------------------------------------------------------------------
module rhc_numer (
   input  logic               clock,
   input  logic               reset,
   input  rhc_pkg::prep_type  prep,
   output rhc_pkg::stage_type dn_stage
);

   logic [rhc_pkg::T_W:0]       sect_span;
   logic [rhc_pkg::T_W:0]       t_full;
   logic [rhc_pkg::T_W-1:0]     t;
   logic [rhc_pkg::NUM_W-1:0]   t_wide;
   logic [rhc_pkg::NUM_W-1:0]   hue_num;
   logic                        valid_ff;
   logic                        valid_in;
   rhc_pkg::stage_data_type     data_ff;
   rhc_pkg::stage_data_type     data_in;

   always_comb begin
      case (prep.sector)
         rhc_pkg::SECTOR_BLUE_MIN:  sect_span = {4'b0, prep.span};
         rhc_pkg::SECTOR_RED_MIN:   sect_span = {4'b0, prep.span} + {3'b0, prep.span, 1'b0};
         rhc_pkg::SECTOR_GREEN_MIN: sect_span = {4'b0, prep.span} + {2'b0, prep.span, 2'b0};
         default:                   sect_span = {4'b0, prep.span};
      endcase
   end

   always_comb begin
      // |diff| never exceeds span, so this stays non-negative
      t_full  = sect_span - {{3{prep.diff[rhc_pkg::DIFF_W-1]}}, prep.diff};
      t       = t_full[rhc_pkg::T_W-1:0];
      t_wide  = {{(rhc_pkg::NUM_W - rhc_pkg::T_W){1'b0}}, t};
      // 2*3840*t + span, for division by 2*span
      hue_num = (t_wide << 13) - (t_wide << 9) + {16'b0, prep.span};
   end

   always_comb begin
      valid_in                = prep.valid;
      data_in.hue_lane.rem    = {3'b0, hue_num[rhc_pkg::NUM_W-1:rhc_pkg::NQ_W]};
      data_in.hue_lane.nq     = hue_num[rhc_pkg::NQ_W-1:0];
      data_in.hue_lane.div    = {prep.span, 1'b0};
      // 2*65536*span + max, for division by 2*max
      data_in.sat_lane.rem    = {2'b0, prep.span};
      data_in.sat_lane.nq     = {9'b0, prep.brightness};
      data_in.sat_lane.div    = {prep.brightness, 1'b0};
      data_in.brightness      = prep.brightness;
      data_in.is_gray         = prep.is_gray;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_stage.valid = valid_ff;
   assign dn_stage.data  = data_ff;

endmodule

@@ hw/rtl/rhc_div_stage.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter, divider stage
// One restoring-division step for the hue and saturation lanes, registered.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_defines.svh"

module rhc_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  rhc_pkg::stage_type up_stage,
   output rhc_pkg::stage_type dn_stage
);

   logic                    valid_ff;
   logic                    valid_in;
   rhc_pkg::stage_data_type data_ff;
   rhc_pkg::stage_data_type data_in;

   always_comb begin
      valid_in            = up_stage.valid;
      data_in             = up_stage.data;
      data_in.hue_lane    = rhc_pkg::div_step(up_stage.data.hue_lane);
      data_in.sat_lane    = rhc_pkg::div_step(up_stage.data.sat_lane);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_stage.valid = valid_ff;
   assign dn_stage.data  = data_ff;

   // partial remainder always stays below the divisor
   `RHC_ASSERT_IMPLY(a_hue_rem_bound, clock, reset, valid_ff && data_ff.hue_lane.div != 0, data_ff.hue_lane.rem < {1'b0, data_ff.hue_lane.div})
   `RHC_ASSERT_IMPLY(a_sat_rem_bound, clock, reset, valid_ff && data_ff.sat_lane.div != 0, data_ff.sat_lane.rem < {1'b0, data_ff.sat_lane.div})
   `RHC_ASSERT_IMPLY(a_div_held, clock, reset, valid_ff && up_stage.valid, data_ff.hue_lane.div == {data_ff.sat_lane.div - data_ff.sat_lane.div + data_ff.hue_lane.div})

endmodule

@@ test/tb_rgb_to_hsv_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Feeds directed and random pixels in bursts and predicts hue, saturation,
// value and the gray flag for each accepted word. It checks every strobed
// result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;

   localparam int HUE_UNITS   = 3840;     // 60 degrees in 1/64 degree
   localparam int SAT_UNITS   = 65536;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PIXELS = 1530;

   typedef struct {
      rhc_pkg::pixel_type pixel;
      bit                 wait_idle;   // hold until every prior result has returned
   } pixel_job_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_start = 1'b0;
   logic               req_busy;
   rhc_pkg::pixel_type req_pixel = '0;
   logic               rsp_strobe;
   rhc_pkg::hsv_type   rsp_result;

   pixel_job_type    pixel_jobs[$];
   rhc_pkg::hsv_type expected_hsv[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               idle_left = 0;

   rgb_to_hsv_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_busy   (req_busy),
      .req_pixel  (req_pixel),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic rhc_pkg::hsv_type convert_pixel(input rhc_pkg::pixel_type px);
      rhc_pkg::hsv_type res;
      int      red, green, blue, top, bottom, span, diff, sector, hue, sat;
      red    = px.red;
      green  = px.green;
      blue   = px.blue;
      top    = red;
      bottom = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      res.brightness = top[rhc_pkg::COMP_W-1:0];
      if (top == bottom) begin
         res.hue        = '0;
         res.saturation = '0;
         res.is_gray    = 1'b1;
      end else begin
         span = top - bottom;
         // ties on the minimum go red first, then blue, then green
         if (red == bottom) begin
            sector = rhc_pkg::SECTOR_RED_MIN;
            diff   = green - blue;
         end else if (blue == bottom) begin
            sector = rhc_pkg::SECTOR_BLUE_MIN;
            diff   = red - green;
         end else begin
            sector = rhc_pkg::SECTOR_GREEN_MIN;
            diff   = blue - red;
         end
         hue = (2 * HUE_UNITS * (sector * span - diff) + span) / (2 * span);
         sat = (2 * SAT_UNITS * span + top) / (2 * top);
         res.hue        = hue[rhc_pkg::HUE_W-1:0];
         res.saturation = sat[rhc_pkg::SAT_W-1:0];
         res.is_gray    = 1'b0;
      end
      return res;
   endfunction

   task automatic queue_pixel(input int red, input int green, input int blue,
                              input bit wait_idle);
      pixel_job_type job;
      job.pixel.red   = red[rhc_pkg::COMP_W-1:0];
      job.pixel.green = green[rhc_pkg::COMP_W-1:0];
      job.pixel.blue  = blue[rhc_pkg::COMP_W-1:0];
      job.wait_idle   = wait_idle;
      pixel_jobs.push_back(job);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // drive on the falling edge, in bursts separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (idle_left != 0) begin
         req_start <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pixel_jobs.size() == 0 ||
                   (pixel_jobs[0].wait_idle && expected_hsv.size() != 0)) begin
         req_start <= 1'b0;
      end else begin
         req_start <= 1'b1;
         req_pixel <= pixel_jobs[0].pixel;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // check the returned word first, then record the newly accepted pixel
   always @(posedge clock) begin
      rhc_pkg::hsv_type want;
      if (!reset && rsp_strobe) begin
         if (expected_hsv.size() == 0) begin
            $display("%0t: unexpected result: expected none, %s %0d sat %0d val %0d gray %0b",
                     $time, "actual hue", rsp_result.hue, rsp_result.saturation,
                     rsp_result.brightness, rsp_result.is_gray);
            mismatch_count++;
         end else begin
            want = expected_hsv.pop_front();
            check_field("hue", want.hue, rsp_result.hue);
            check_field("saturation", want.saturation, rsp_result.saturation);
            check_field("brightness", want.brightness, rsp_result.brightness);
            check_field("is_gray", want.is_gray, rsp_result.is_gray);
         end
      end
      if (req_start && !req_busy) begin
         expected_hsv.push_back(convert_pixel(req_pixel));
         void'(pixel_jobs.pop_front());
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int a, b, c, pick;
      // gray levels, primaries, secondaries and tie orders on the minimum
      queue_pixel(0, 0, 0, 1'b0);
      queue_pixel(255, 255, 255, 1'b0);
      queue_pixel(128, 128, 128, 1'b0);
      queue_pixel(255, 0, 0, 1'b0);
      queue_pixel(0, 255, 0, 1'b0);
      queue_pixel(0, 0, 255, 1'b0);
      queue_pixel(255, 255, 0, 1'b0);
      queue_pixel(0, 255, 255, 1'b0);
      queue_pixel(255, 0, 255, 1'b0);
      queue_pixel(1, 0, 0, 1'b0);
      queue_pixel(0, 1, 1, 1'b0);
      queue_pixel(1, 1, 0, 1'b0);
      queue_pixel(255, 0, 1, 1'b0);
      queue_pixel(255, 1, 0, 1'b0);
      queue_pixel(0, 255, 254, 1'b0);
      queue_pixel(254, 255, 255, 1'b0);
      queue_pixel(255, 254, 254, 1'b0);
      queue_pixel(1, 2, 3, 1'b0);
      queue_pixel(200, 100, 150, 1'b0);
      queue_pixel(10, 250, 130, 1'b1);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         a    = $urandom_range(0, 255);
         b    = $urandom_range(0, 255);
         c    = $urandom_range(0, 255);
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               b = a;
               c = a;
            end
            1: begin
               case ($urandom_range(0, 2))
                  0: b = a;
                  1: c = a;
                  default: c = b;
               endcase
            end
            2: begin
               a = ($urandom_range(0, 2) == 0) ? a : 255 * $urandom_range(0, 1);
               b = ($urandom_range(0, 2) == 0) ? b : 255 * $urandom_range(0, 1);
               c = ($urandom_range(0, 2) == 0) ? c : 255 * $urandom_range(0, 1);
            end
            default: ;
         endcase
         queue_pixel(a, b, c, (i % 400) == 399);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pixel_jobs.size() != 0 || expected_hsv.size() != 0) @(negedge clock);
      repeat (rhc_pkg::LATENCY + 4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_prep.sv
hw/rtl/rhc_numer.sv
hw/rtl/rhc_div_stage.sv
hw/rtl/rgb_to_hsv_converter.sv
test/tb_rgb_to_hsv_converter.sv
